>>> rtl/tnc_pkg.sv
package tnc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int USE_W   = 4;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_GRANT,
        ST_SCAN,
        ST_REMOVE,
        ST_APPEND,
        ST_PURGE,
        ST_FINISH
    } state_t;

    typedef enum logic {
        SCAN_LOOKUP,
        SCAN_EVICT
    } scan_mode_t;

    typedef struct packed {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [31:0] address;
        logic [31:0] expiry;
    } entry_t;

    typedef struct packed {
        logic             hit;
        logic [31:0]      address;
        logic [31:0]      expiry;
        logic [IDX_W-1:0] pos;
    } scan_t;

    typedef struct packed {
        logic       valid;
        logic       shift;
        logic       load;
        scan_mode_t mode;
    } cell_ctl_t;

endpackage

>>> rtl/tnc_ifs.sv
interface tnc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [31:0] new_address;
    logic [31:0] expiry_in;
    logic [31:0] now;

    modport source (
        output valid, action, key_hi, key_lo, new_address, expiry_in, now,
        input  ready
    );
    modport sink (
        input  valid, action, key_hi, key_lo, new_address, expiry_in, now,
        output ready
    );
endinterface

interface tnc_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] address;
    logic [31:0] expiry;
    logic [3:0]  entries_in_use;

    modport source (
        output valid, found, address, expiry, entries_in_use,
        input  ready
    );
    modport sink (
        input  valid, found, address, expiry, entries_in_use,
        output ready
    );
endinterface

interface tnc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

>>> rtl/ttl_name_cache_table.sv
// Channel  Dir  Handshake    Payload
// req      in   valid/ready  action, key_hi, key_lo, new_address, expiry_in, now
// rsp      out  valid/ready  found, address, expiry, entries_in_use
// cfg      in   valid/ready  data (min_ttl)
//
// One request at a time. Lookup: the key is carried through the registered scan chain
// that runs through every cell. Tick: one expired entry removed per cycle by shifting
// the cells behind it, until none is left. Insert: clamp, grant, append, then purge;
// a full table first runs an eviction scan and removes the entry that it found.
// Reset clears the entry count, min_ttl and the handshake state; the cells
// hold no reset. A stalled response waits in its register while the next
// request is taken.
module ttl_name_cache_table (
    input  logic       clk,
    input  logic       rst_n,
    tnc_req_if.sink    req,
    tnc_rsp_if.source  rsp,
    tnc_cfg_if.sink    cfg
);

    localparam int N = tnc_pkg::ENTRIES;

    tnc_pkg::state_t     state_reg, state_next;
    tnc_pkg::scan_mode_t mode_reg, mode_next;
    logic [tnc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [tnc_pkg::IDX_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [31:0]               min_ttl_reg;

    logic [1:0]      action_reg;
    tnc_pkg::entry_t req_entry_reg;
    tnc_pkg::entry_t append_entry;
    logic [31:0]     now_reg;
    logic [31:0]     floor_reg, floor_next;
    logic [31:0]     granted_reg, granted_next;
    logic [32:0]     floor_sum;

    logic            out_valid_reg, out_valid_next;
    logic            out_found_reg, out_found_next;
    logic [31:0]     out_address_reg, out_address_next;
    logic [31:0]     out_expiry_reg, out_expiry_next;
    logic [3:0]      out_use_reg, out_use_next;

    tnc_pkg::entry_t    cell_entry [N];
    tnc_pkg::scan_t     scan_link [N+1];
    tnc_pkg::cell_ctl_t cell_ctl [N];
    logic [N-1:0]       cell_expired;
    logic [N-1:0]       drop;
    logic [N-1:0]       shift;
    logic               any_drop;
    logic               req_fire;
    tnc_pkg::scan_t     scan_last;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == tnc_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;
    assign scan_link[0] = '0;
    assign scan_last = scan_link[N];
    assign any_drop  = shift[N-1];
    assign floor_sum = {1'b0, now_reg} + {1'b0, min_ttl_reg};
    assign append_entry = {req_entry_reg.key_hi, req_entry_reg.key_lo,
                           req_entry_reg.address, granted_reg};

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        assign drop[g] = (state_reg == tnc_pkg::ST_PURGE) ? cell_expired[g]
                       : ((state_reg == tnc_pkg::ST_REMOVE)
                          && (scan_last.pos == tnc_pkg::IDX_W'(g)));

        if (g == 0)
        begin : g_first
            assign shift[g] = drop[g];
        end
        else
        begin : g_rest
            assign shift[g] = shift[g-1] | drop[g];
        end

        assign cell_ctl[g].valid = (tnc_pkg::CNT_W'(g) < count_reg);
        assign cell_ctl[g].shift = shift[g];
        assign cell_ctl[g].load  = (state_reg == tnc_pkg::ST_APPEND)
                                && (count_reg == tnc_pkg::CNT_W'(g));
        assign cell_ctl[g].mode  = mode_reg;

        tnc_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[g]),
            .index      (tnc_pkg::IDX_W'(g)),
            .new_entry  (append_entry),
            .next_entry (cell_entry[(g + 1 < N) ? g + 1 : g]),
            .now        (now_reg),
            .scan_in    (scan_link[g]),
            .entry      (cell_entry[g]),
            .expired    (cell_expired[g]),
            .scan_out   (scan_link[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tnc_pkg::ST_IDLE;
            count_reg     <= '0;
            min_ttl_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                min_ttl_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        scan_cnt_reg    <= scan_cnt_next;
        floor_reg       <= floor_next;
        granted_reg     <= granted_next;
        out_found_reg   <= out_found_next;
        out_address_reg <= out_address_next;
        out_expiry_reg  <= out_expiry_next;
        out_use_reg     <= out_use_next;
        if (req_fire)
        begin
            action_reg            <= req.action;
            req_entry_reg.key_hi  <= req.key_hi;
            req_entry_reg.key_lo  <= req.key_lo;
            req_entry_reg.address <= req.new_address;
            req_entry_reg.expiry  <= req.expiry_in;
            now_reg               <= req.now;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        count_next       = count_reg;
        scan_cnt_next    = scan_cnt_reg;
        floor_next       = floor_reg;
        granted_next     = granted_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_found_next   = out_found_reg;
        out_address_next = out_address_reg;
        out_expiry_next  = out_expiry_reg;
        out_use_next     = out_use_reg;

        unique case (state_reg)
            tnc_pkg::ST_IDLE:
            begin
                scan_cnt_next = '0;
                mode_next     = tnc_pkg::SCAN_LOOKUP;
                if (req_fire)
                begin
                    case (req.action)
                        tnc_pkg::ACT_LOOKUP: state_next = tnc_pkg::ST_SCAN;
                        tnc_pkg::ACT_INSERT: state_next = tnc_pkg::ST_CLAMP;
                        tnc_pkg::ACT_TICK:   state_next = tnc_pkg::ST_PURGE;
                        default:             state_next = tnc_pkg::ST_FINISH;
                    endcase
                end
            end
            tnc_pkg::ST_CLAMP:
            begin
                floor_next = floor_sum[32] ? 32'hFFFF_FFFF : floor_sum[31:0];
                state_next = tnc_pkg::ST_GRANT;
            end
            tnc_pkg::ST_GRANT:
            begin
                granted_next = (req_entry_reg.expiry > floor_reg) ? req_entry_reg.expiry
                                                                  : floor_reg;
                scan_cnt_next = '0;
                mode_next     = tnc_pkg::SCAN_EVICT;
                state_next    = (count_reg == tnc_pkg::CNT_W'(N)) ? tnc_pkg::ST_SCAN
                                                                 : tnc_pkg::ST_APPEND;
            end
            tnc_pkg::ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == tnc_pkg::IDX_W'(N - 1))
                begin
                    state_next = (mode_reg == tnc_pkg::SCAN_EVICT) ? tnc_pkg::ST_REMOVE
                                                                   : tnc_pkg::ST_FINISH;
                end
            end
            tnc_pkg::ST_REMOVE:
            begin
                count_next = count_reg - 1'b1;
                state_next = tnc_pkg::ST_APPEND;
            end
            tnc_pkg::ST_APPEND:
            begin
                count_next = count_reg + 1'b1;
                state_next = tnc_pkg::ST_PURGE;
            end
            tnc_pkg::ST_PURGE:
            begin
                if (any_drop)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    state_next = tnc_pkg::ST_FINISH;
                end
            end
            tnc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_found_next   = 1'b0;
                    out_address_next = '0;
                    out_expiry_next  = '0;
                    out_use_next     = tnc_pkg::USE_W'(count_reg);
                    case (action_reg)
                        tnc_pkg::ACT_LOOKUP:
                        begin
                            if (scan_last.hit)
                            begin
                                out_found_next   = 1'b1;
                                out_address_next = scan_last.address;
                                out_expiry_next  = scan_last.expiry;
                            end
                        end
                        tnc_pkg::ACT_INSERT:
                        begin
                            out_expiry_next = granted_reg;
                        end
                        default:
                        begin
                            out_found_next = 1'b0;
                        end
                    endcase
                    state_next = tnc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tnc_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.found          = out_found_reg;
    assign rsp.address        = out_address_reg;
    assign rsp.expiry         = out_expiry_reg;
    assign rsp.entries_in_use = out_use_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tnc_pkg::CNT_W'(N))
        else $error("entry count beyond table size");

    a_purge_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tnc_pkg::ST_PURGE) && any_drop
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("purge did not remove exactly one entry");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tnc_pkg::ST_APPEND) |-> count_reg < tnc_pkg::CNT_W'(N))
        else $error("append into a full table");

    a_evict_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tnc_pkg::ST_REMOVE) |-> scan_last.hit)
        else $error("eviction scan found no entry");

endmodule

>>> rtl/tnc_cell.sv
module tnc_cell (
    input  logic                            clk,
    input  tnc_pkg::cell_ctl_t              ctl,
    input  logic [tnc_pkg::IDX_W-1:0]       index,
    input  tnc_pkg::entry_t                 new_entry,
    input  tnc_pkg::entry_t                 next_entry,
    input  logic [31:0]                     now,
    input  tnc_pkg::scan_t                  scan_in,
    output tnc_pkg::entry_t                 entry,
    output logic                            expired,
    output tnc_pkg::scan_t                  scan_out
);

    tnc_pkg::entry_t entry_reg;
    tnc_pkg::entry_t entry_next;
    tnc_pkg::scan_t  scan_reg;
    tnc_pkg::scan_t  scan_next;
    logic            key_match;

    assign key_match = (entry_reg.key_hi == new_entry.key_hi)
                    && (entry_reg.key_lo == new_entry.key_lo);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load)
        begin
            entry_next = new_entry;
        end
        else if (ctl.shift)
        begin
            entry_next = next_entry;
        end
    end

    always_comb
    begin
        scan_next = scan_in;
        case (ctl.mode)
            tnc_pkg::SCAN_LOOKUP:
            begin
                if (!scan_in.hit && ctl.valid && key_match)
                begin
                    scan_next.hit     = 1'b1;
                    scan_next.address = entry_reg.address;
                    scan_next.expiry  = entry_reg.expiry;
                    scan_next.pos     = index;
                end
            end
            default:
            begin
                // keep the earlier entry on equal expiry
                if (ctl.valid && (!scan_in.hit || (entry_reg.expiry < scan_in.expiry)))
                begin
                    scan_next.hit     = 1'b1;
                    scan_next.address = entry_reg.address;
                    scan_next.expiry  = entry_reg.expiry;
                    scan_next.pos     = index;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        scan_reg  <= scan_next;
    end

    assign entry    = entry_reg;
    assign expired  = ctl.valid && (entry_reg.expiry <= now);
    assign scan_out = scan_reg;

endmodule
